/* rtl/mtss_pkg.sv */
`default_nettype none
package mtss_pkg;
  localparam int unsigned N = 624;
  localparam int unsigned M = 397;
  localparam int unsigned AW = 10;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
  localparam logic [31:0] MATRIX = 32'h9908b0df;
  localparam logic [31:0] UPPER = 32'h80000000;
  localparam logic [31:0] LOWER = 32'h7fffffff;
  localparam logic [31:0] MULT = 32'd6069;
  localparam logic [31:0] DEF_SEED = 32'd4357;

  typedef enum logic [2:0] {
    OP_NEXT = 3'd0, OP_RANGE = 3'd1, OP_SEED = 3'd2, OP_PUSH = 3'd3, OP_POP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2
  } status_e;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction
endpackage
`default_nettype wire

/* rtl/mtss_ram.sv */
`default_nettype none
module mtss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624,
  localparam int unsigned AWIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AWIDTH-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [AWIDTH-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/mtss_div.sv */
`default_nettype none
module mtss_div import mtss_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [32:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [32:0]      quo_o
);
  logic [32:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q; busy_d = busy_q;
    done_o = 1'b0;
    trial = {rem_q, quo_q[32]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0; quo_d = num_i; den_d = den_i; cnt_d = 6'd33; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[32]};
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
    quo_o = quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end
endmodule
`default_nettype wire

/* rtl/mersenne_twister_seed_stack_top.sv */
// Next word: read from the store and tempered; when the seeded store is used up, a twist runs first.
// Reseed and push walk the store one word a cycle; pop first reads the seed back from the stack.
// Ranged output adds two passes of the bit-serial divider.
// Throughput: one transaction at a time; busy is high while one is at work.
// Reset: asynchronous, active low; store reads as zero until first seeded.
// Results appear on done_o for one cycle; the receiver cannot stall.
`default_nettype none
module mersenne_twister_seed_stack_top import mtss_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         opcode_i,
  input  wire logic [31:0]        seed_value_i,
  input  wire logic signed [15:0] range_low_i,
  input  wire logic signed [15:0] range_high_i,
  output logic                    done_o,
  output logic [31:0]             word_o,
  output logic signed [15:0]      ranged_value_o,
  output logic [1:0]              status_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_TW_A, S_TW_B, S_TW_C, S_RD, S_RD2,
    S_DIV1, S_DIV1W, S_DIV2, S_DIV2W, S_POPR, S_POPW, S_OUT
  } state_e;

  state_e       state_q, state_d;
  logic [2:0]   op_q, op_d;
  logic signed [15:0] lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0] pos_q, pos_d, k_q, k_d;
  logic         seeded_q, seeded_d;
  logic [31:0]  cur_q, cur_d, prev_q, prev_d;
  logic [31:0]  yk_q, yk_d, yn_q, yn_d;
  logic [SCW-1:0] cnt_q, cnt_d;
  logic [31:0]  word_q, word_d;
  logic signed [15:0] rng_q, rng_d;
  logic [1:0]   st_q, st_d;
  logic [32:0]  dq_q, dq_d;

  logic          we, s_we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata, s_rdata;
  logic [SAW-1:0] s_addr;
  logic          dv_start, dv_done;
  logic [32:0]   dv_num, dv_den, dv_quo;
  logic [31:0]   y, tw;
  logic [16:0]   span;

  mtss_ram #(.WIDTH(32), .DEPTH(N)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );
  mtss_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_addr), .wdata_i(cur_q), .raddr_i(s_addr),
    .rdata_o(s_rdata)
  );
  mtss_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(N)) s = s - (AW+1)'(N);
    return s[AW-1:0];
  endfunction

  assign busy = (state_q != S_IDLE);
  assign y = (yk_q & UPPER) | (yn_q & LOWER);
  assign tw = rdata ^ (y >> 1) ^ (y[0] ? MATRIX : 32'd0);
  assign span = 17'($signed(hi_q)) - 17'($signed(lo_q));

  always_comb begin
    state_d = state_q; op_d = op_q; lo_d = lo_q; hi_d = hi_q;
    pos_d = pos_q; k_d = k_q; seeded_d = seeded_q; cur_d = cur_q; prev_d = prev_q;
    yk_d = yk_q; yn_d = yn_q; cnt_d = cnt_q; word_d = word_q; rng_d = rng_q;
    st_d = st_q; dq_d = dq_q;
    we = 1'b0; waddr = k_q; wdata = prev_q; raddr = k_q; s_we = 1'b0;
    s_addr = cnt_q[SAW-1:0]; dv_start = 1'b0; dv_num = '0; dv_den = 33'd1;
    done_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = opcode_i; lo_d = range_low_i; hi_d = range_high_i;
          word_d = '0; rng_d = '0; st_d = ST_OK;
          state_d = S_OUT;
          case (opcode_i)
            OP_NEXT: state_d = S_RD;
            OP_RANGE: begin
              if (range_low_i >= range_high_i) rng_d = range_low_i;
              else state_d = S_DIV1;
            end
            OP_SEED: begin
              prev_d = seed_value_i; cur_d = seed_value_i; k_d = '0; state_d = S_SEED;
            end
            OP_PUSH: begin
              if (cnt_q == SCW'(STACK_DEPTH)) st_d = ST_FULL;
              else begin
                s_we = 1'b1; cnt_d = cnt_q + 1'b1;
                prev_d = seed_value_i; cur_d = seed_value_i; k_d = '0; state_d = S_SEED;
              end
            end
            OP_POP: begin
              if (cnt_q == '0) st_d = ST_EMPTY;
              else begin
                word_d = cur_q; cnt_d = cnt_q - 1'b1; state_d = S_POPR;
              end
            end
            default: ;
          endcase
        end
      end
      S_POPR: state_d = S_POPW;
      S_POPW: begin
        prev_d = s_rdata; cur_d = s_rdata; k_d = '0; state_d = S_SEED;
      end
      S_SEED: begin
        we = 1'b1;
        prev_d = prev_q * MULT;
        k_d = k_q + 1'b1;
        if (k_q == AW'(N - 1)) begin
          pos_d = AW'(N); seeded_d = 1'b1; state_d = S_OUT;
        end
      end
      S_DIV1: begin
        dv_start = 1'b1; dv_num = 33'h0ffffffff; dv_den = 33'(span) + 33'd1;
        state_d = S_DIV1W;
      end
      S_DIV1W: if (dv_done) begin
        dq_d = dv_quo + 33'd1; state_d = S_RD;
      end
      S_RD: begin
        if (pos_q >= AW'(N) && seeded_q) begin
          k_d = '0; raddr = '0; state_d = S_TW_A;
        end else begin
          if (pos_q >= AW'(N)) pos_d = '0;
          raddr = (pos_q >= AW'(N)) ? '0 : pos_q;
          state_d = S_RD2;
        end
      end
      S_RD2: begin
        word_d = temper(seeded_q ? rdata : 32'd0);
        pos_d = pos_q + 1'b1;
        if (op_q == OP_RANGE) state_d = S_DIV2;
        else state_d = S_OUT;
      end
      S_TW_A: begin
        yk_d = rdata; raddr = wrap(k_q, AW'(1)); state_d = S_TW_B;
      end
      S_TW_B: begin
        yn_d = rdata; raddr = wrap(k_q, AW'(M)); state_d = S_TW_C;
      end
      S_TW_C: begin
        we = 1'b1; wdata = tw; raddr = wrap(k_q, AW'(1));
        if (k_q == AW'(N - 1)) begin
          pos_d = '0; state_d = S_RD;
        end else begin
          k_d = k_q + 1'b1; state_d = S_TW_A;
        end
      end
      S_DIV2: begin
        dv_start = 1'b1; dv_num = {1'b0, word_q}; dv_den = dq_q; state_d = S_DIV2W;
      end
      S_DIV2W: if (dv_done) begin
        rng_d = lo_q + 16'(dv_quo); state_d = S_OUT;
      end
      S_OUT: begin
        done_o = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign word_o = word_q;
  assign ranged_value_o = rng_q;
  assign status_o = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pos_q <= '0; seeded_q <= 1'b0; cur_q <= 32'd1; cnt_q <= '0;
      word_q <= '0; rng_q <= '0; st_q <= ST_OK;
    end else begin
      state_q <= state_d; pos_q <= pos_d; seeded_q <= seeded_d; cur_q <= cur_d;
      cnt_q <= cnt_d; word_q <= word_d; rng_q <= rng_d; st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; lo_q <= lo_d; hi_q <= hi_d; k_q <= k_d;
    prev_q <= prev_d; yk_q <= yk_d; yn_q <= yn_d; dq_q <= dq_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy);
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= SCW'(STACK_DEPTH))
    else $error("stack count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= AW'(N))
    else $error("read position out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && st_q != ST_OK) |-> (word_q == '0 && rng_q == '0))
    else $error("flagged result not zero");
endmodule
`default_nettype wire
